/* rtl/gtpu_packet_header_parser_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef GTPU_PACKET_HEADER_PARSER_DEFINES_SVH
`define GTPU_PACKET_HEADER_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define GTPU_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("gtpu assertion failed");
`define GTPU_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("gtpu assertion failed");
`else
`define GTPU_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define GTPU_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* rtl/gtpu_pkg.sv */
package gtpu_pkg;

    localparam int INNER_CAPTURE_BYTES = 64;
    localparam int POS_W               = 17;
    localparam int ADDR_BYTES          = 32;

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    localparam logic [2:0] STATUS_REJECT   = 3'd0;
    localparam logic [2:0] STATUS_CONTROL  = 3'd1;
    localparam logic [2:0] STATUS_GPDU     = 3'd2;
    localparam logic [2:0] STATUS_V4       = 3'd3;
    localparam logic [2:0] STATUS_V4_PORTS = 3'd4;
    localparam logic [2:0] STATUS_V6       = 3'd5;
    localparam logic [2:0] STATUS_V6_PORTS = 3'd6;

    localparam logic [1:0] EXT_IDLE = 2'd0;
    localparam logic [1:0] EXT_LEN  = 2'd1;
    localparam logic [1:0] EXT_NEXT = 2'd2;
    localparam logic [1:0] EXT_FAIL = 2'd3;

    localparam logic [7:0] MSG_GPDU  = 8'hFF;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] OPT_MASK  = 8'h07;
    localparam logic [7:0] EXT_FLAG  = 8'h04;
    localparam logic [3:0] IP_VER4   = 4'd4;
    localparam logic [3:0] IP_VER6   = 4'd6;

endpackage

/* rtl/gtpu_ifs.sv */
interface gtpu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface gtpu_out_if;
    logic        valid;
    logic        ready;
    logic        last_result;
    logic [63:0] addr_word;
    logic [2:0]  status;
    logic [7:0]  msg_kind;
    logic [31:0] tunnel_id;
    logic [15:0] seq_no;
    logic [7:0]  ext_header_count;
    logic        ext_chain_ok;
    logic [7:0]  inner_protocol;
    logic [31:0] port_pair;
    logic [16:0] pay_offset;
    logic [15:0] pay_length;

    modport source (output valid, output last_result, output addr_word, output status,
                    output msg_kind, output tunnel_id, output seq_no,
                    output ext_header_count, output ext_chain_ok, output inner_protocol,
                    output port_pair, output pay_offset, output pay_length,
                    input ready);
    modport sink   (input valid, input last_result, input addr_word, input status,
                    input msg_kind, input tunnel_id, input seq_no,
                    input ext_header_count, input ext_chain_ok, input inner_protocol,
                    input port_pair, input pay_offset, input pay_length,
                    output ready);
endinterface

/* rtl/gtpu_packet_header_parser.sv */
// Channel     Dir  Payload
// pkt_bytes   in   data_byte, last_byte
// results     out  summary then address words, last_result on the final one
//
// One packet byte per cycle while pkt_bytes.ready is high; header, extension chain and inner capture update per byte.
// The last byte moves the packet into a snapshot stage; it enters the result stage once that stage has drained.
// A packet yields 1, 3 or 5 result transfers, one per cycle while results.ready is high.
// pkt_bytes.ready drops only while a snapshot waits for the result stage to drain.
// Reset (rst_n low, asynchronous) empties both stages and clears the parse state.
`include "gtpu_packet_header_parser_defines.svh"

module gtpu_packet_header_parser #(
    parameter int INNER_CAPTURE_BYTES = gtpu_pkg::INNER_CAPTURE_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    gtpu_in_if.sink           pkt_bytes,
    gtpu_out_if.source        results
);

    localparam int AB = gtpu_pkg::ADDR_BYTES;

    // parse state
    gtpu_pkg::pos_t pos_reg, pos_next;
    logic [7:0]     flag_reg, flag_next;
    logic [7:0]     msg_reg, msg_next;
    logic [15:0]    dl_reg, dl_next;
    logic [31:0]    tid_reg, tid_next;
    logic [15:0]    seq_reg, seq_next;
    logic [7:0]     nek_reg, nek_next;
    gtpu_pkg::pos_t bnd_reg, bnd_next;
    logic [7:0]     cnt_reg, cnt_next;
    logic [1:0]     est_reg, est_next;
    gtpu_pkg::pos_t ins_reg, ins_next;

    // captured inner bytes
    logic [7:0] b0_reg, b0_next, b6_reg, b6_next, b9_reg, b9_next;
    logic [7:0] addr_reg [AB];
    logic [7:0] addr_next [AB];
    logic [7:0] v4p_reg [4];
    logic [7:0] v4p_next [4];
    logic [7:0] v6p_reg [4];
    logic [7:0] v6p_next [4];

    // snapshot
    logic           snap_valid_reg;
    gtpu_pkg::pos_t sn_pos_reg, sn_ins_reg;
    logic [7:0]     sn_flag_reg, sn_msg_reg, sn_cnt_reg;
    logic [15:0]    sn_dl_reg, sn_seq_reg;
    logic [31:0]    sn_tid_reg;
    logic           sn_fail_reg;
    logic [7:0]     sn_b0_reg, sn_b6_reg, sn_b9_reg;
    logic [7:0]     sn_addr_reg [AB];
    logic [7:0]     sn_v4p_reg [4];
    logic [7:0]     sn_v6p_reg [4];

    // result stage
    logic        res_valid_reg;
    logic [2:0]  res_idx_reg, res_nw_reg;
    logic [2:0]  res_status_reg;
    logic [7:0]  res_msg_reg, res_cnt_reg, res_proto_reg;
    logic [31:0] res_tid_reg, res_ports_reg;
    logic [15:0] res_seq_reg, res_plen_reg;
    logic        res_ok_reg;
    logic [16:0] res_poff_reg;
    logic [63:0] res_words_reg [4];

    logic in_fire, out_fire, out_last, snap_adv;

    assign in_fire  = pkt_bytes.valid && pkt_bytes.ready;
    assign out_last = (res_idx_reg == res_nw_reg);
    assign out_fire = results.valid && results.ready;
    assign snap_adv = snap_valid_reg && (!res_valid_reg || (out_fire && out_last));
    assign pkt_bytes.ready = !snap_valid_reg || snap_adv;

    // per-byte parse
    logic [7:0]     d;
    gtpu_pkg::pos_t p, t, bh_b, idx;
    logic           bh_go, cap_en;
    logic [17:0]    endv;
    logic [6:0]     ihl_cur;

    always_comb
    begin
        d = pkt_bytes.data_byte;
        p = pos_reg;
        flag_next = flag_reg;
        msg_next  = msg_reg;
        dl_next   = dl_reg;
        tid_next  = tid_reg;
        seq_next  = seq_reg;
        nek_next  = nek_reg;
        bnd_next  = bnd_reg;
        cnt_next  = cnt_reg;
        est_next  = est_reg;
        ins_next  = ins_reg;
        bh_go     = 1'b0;
        bh_b      = 17'd12;
        endv      = '0;

        if (p == 17'd0)
        begin
            flag_next = d;
            if ((d & gtpu_pkg::OPT_MASK) == 8'd0)
                ins_next = 17'd8;
        end
        else if (p == 17'd1)
            msg_next = d;
        else if (p == 17'd2)
            dl_next = {d, dl_reg[7:0]};
        else if (p == 17'd3)
            dl_next = {dl_reg[15:8], d};
        else if (p >= 17'd4 && p <= 17'd7)
            tid_next = {tid_reg[23:0], d};
        else if (p == 17'd8 || p == 17'd9)
            seq_next = {seq_reg[7:0], d};
        else if (p == 17'd11 && (flag_reg & gtpu_pkg::OPT_MASK) != 8'd0)
        begin
            nek_next = ((flag_reg & gtpu_pkg::EXT_FLAG) != 8'd0) ? d : 8'd0;
            bh_go = 1'b1;
            bh_b  = 17'd12;
        end

        t = 17'd8 + {1'b0, dl_next};

        if (p >= 17'd12 && p < t)
        begin
            if (est_reg == gtpu_pkg::EXT_LEN && p == bnd_reg)
            begin
                endv = {1'b0, p} + {8'd0, d, 2'b00};
                if (d == 8'd0 || endv > {1'b0, t})
                begin
                    est_next = gtpu_pkg::EXT_FAIL;
                    ins_next = p;
                end
                else
                begin
                    bnd_next = endv[16:0];
                    est_next = gtpu_pkg::EXT_NEXT;
                end
            end
            else if (est_reg == gtpu_pkg::EXT_NEXT && ({1'b0, p} + 18'd1) == {1'b0, bnd_reg})
            begin
                nek_next = d;
                if (cnt_reg != 8'hFF)
                    cnt_next = cnt_reg + 8'd1;
                bh_go = 1'b1;
                bh_b  = bnd_reg;
            end
        end

        if (bh_go)
        begin
            if (nek_next == 8'd0 || bh_b >= t)
            begin
                est_next = gtpu_pkg::EXT_IDLE;
                ins_next = bh_b;
            end
            else if (({1'b0, bh_b} + 18'd2) > {1'b0, t})
            begin
                est_next = gtpu_pkg::EXT_FAIL;
                ins_next = bh_b;
            end
            else
            begin
                est_next = gtpu_pkg::EXT_LEN;
                bnd_next = bh_b;
            end
        end

        pos_next = (p == gtpu_pkg::POS_MAX) ? p : p + 17'd1;

        idx    = p - ins_next;
        cap_en = (p >= 17'd8) && (p < t) && (ins_next != 17'd0) && (p >= ins_next)
                 && (idx < 17'(INNER_CAPTURE_BYTES));
        ihl_cur = {1'b0, b0_reg[3:0], 2'b00};

        b0_next = (cap_en && idx == 17'd0) ? d : b0_reg;
        b6_next = (cap_en && idx == 17'd6) ? d : b6_reg;
        b9_next = (cap_en && idx == 17'd9) ? d : b9_reg;
        for (int i = 0; i < AB; i++)
            addr_next[i] = (cap_en && idx == 17'(i + 8)) ? d : addr_reg[i];
        for (int k = 0; k < 4; k++)
        begin
            v6p_next[k] = (cap_en && idx == 17'(k + 40)) ? d : v6p_reg[k];
            v4p_next[k] = (cap_en && idx == {10'd0, ihl_cur} + 17'(k)) ? d : v4p_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            flag_reg <= '0;
            msg_reg  <= '0;
            dl_reg   <= '0;
            tid_reg  <= '0;
            seq_reg  <= '0;
            nek_reg  <= '0;
            bnd_reg  <= 17'd12;
            cnt_reg  <= '0;
            est_reg  <= gtpu_pkg::EXT_IDLE;
            ins_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (pkt_bytes.last_byte)
            begin
                pos_reg  <= '0;
                flag_reg <= '0;
                msg_reg  <= '0;
                dl_reg   <= '0;
                tid_reg  <= '0;
                seq_reg  <= '0;
                nek_reg  <= '0;
                bnd_reg  <= 17'd12;
                cnt_reg  <= '0;
                est_reg  <= gtpu_pkg::EXT_IDLE;
                ins_reg  <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                flag_reg <= flag_next;
                msg_reg  <= msg_next;
                dl_reg   <= dl_next;
                tid_reg  <= tid_next;
                seq_reg  <= seq_next;
                nek_reg  <= nek_next;
                bnd_reg  <= bnd_next;
                cnt_reg  <= cnt_next;
                est_reg  <= est_next;
                ins_reg  <= ins_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            b0_reg <= b0_next;
            b6_reg <= b6_next;
            b9_reg <= b9_next;
            addr_reg <= addr_next;
            v4p_reg  <= v4p_next;
            v6p_reg  <= v6p_next;
        end
        if (in_fire && pkt_bytes.last_byte)
        begin
            sn_pos_reg  <= pos_next;
            sn_ins_reg  <= ins_next;
            sn_flag_reg <= flag_next;
            sn_msg_reg  <= msg_next;
            sn_cnt_reg  <= cnt_next;
            sn_dl_reg   <= dl_next;
            sn_seq_reg  <= seq_next;
            sn_tid_reg  <= tid_next;
            sn_fail_reg <= (est_next == gtpu_pkg::EXT_FAIL);
            sn_b0_reg   <= b0_next;
            sn_b6_reg   <= b6_next;
            sn_b9_reg   <= b9_next;
            sn_addr_reg <= addr_next;
            sn_v4p_reg  <= v4p_next;
            sn_v6p_reg  <= v6p_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (in_fire && pkt_bytes.last_byte)
            snap_valid_reg <= 1'b1;
        else if (snap_adv)
            snap_valid_reg <= 1'b0;
    end

    // packet summary from the snapshot
    gtpu_pkg::pos_t ft, ip_len;
    logic        f_accept, f_hdr;
    logic [17:0] off_ext;
    logic [6:0]  ihl;
    logic [3:0]  ver;
    logic [2:0]  f_status, f_nw;
    logic [7:0]  f_proto;
    logic [31:0] f_ports;
    logic [16:0] f_poff;
    logic [15:0] f_plen;
    logic [63:0] f_words [4];
    logic [7:0]  v4b [4];

    always_comb
    begin
        ft      = 17'd8 + {1'b0, sn_dl_reg};
        f_hdr   = (sn_flag_reg & gtpu_pkg::OPT_MASK) != 8'd0;
        off_ext = {1'b0, sn_ins_reg};
        ip_len  = ft - sn_ins_reg;
        ihl     = {1'b0, sn_b0_reg[3:0], 2'b00};
        ver     = (sn_ins_reg != 17'd0) ? sn_b0_reg[7:4] : 4'd0;
        f_accept = (sn_pos_reg >= 17'd8) && (sn_flag_reg[7:5] == 3'd1) && sn_flag_reg[4]
                   && (sn_pos_reg >= (f_hdr ? 17'd12 : 17'd8)) && (sn_pos_reg >= ft);
        f_status = gtpu_pkg::STATUS_REJECT;
        f_nw     = 3'd0;
        f_proto  = '0;
        f_ports  = '0;
        f_poff   = '0;
        f_plen   = '0;
        for (int k = 0; k < 4; k++)
        begin
            f_words[k] = '0;
            v4b[k] = ({10'd0, ihl} + 17'(k) < 17'(INNER_CAPTURE_BYTES)) ? sn_v4p_reg[k] : 8'd0;
        end

        if (f_accept)
        begin
            if (sn_msg_reg != gtpu_pkg::MSG_GPDU)
                f_status = gtpu_pkg::STATUS_CONTROL;
            else
            begin
                f_status = gtpu_pkg::STATUS_GPDU;
                if (sn_ins_reg < ft && off_ext + 18'd20 <= {1'b0, ft})
                begin
                    if (ver == gtpu_pkg::IP_VER4)
                    begin
                        if (ihl >= 7'd20 && off_ext + 18'(ihl) <= {1'b0, ft})
                        begin
                            f_status = gtpu_pkg::STATUS_V4;
                            f_proto  = sn_b9_reg;
                            if ((sn_b9_reg == gtpu_pkg::PROTO_TCP
                                 || sn_b9_reg == gtpu_pkg::PROTO_UDP)
                                && off_ext + 18'(ihl) + 18'd4 <= {1'b0, ft})
                            begin
                                f_status = gtpu_pkg::STATUS_V4_PORTS;
                                f_ports  = {v4b[0], v4b[1], v4b[2], v4b[3]};
                            end
                            f_poff = sn_ins_reg + 17'(ihl);
                            f_plen = 16'(ip_len - 17'(ihl));
                            f_words[0] = {32'd0, sn_addr_reg[4], sn_addr_reg[5],
                                          sn_addr_reg[6], sn_addr_reg[7]};
                            f_words[1] = {32'd0, sn_addr_reg[8], sn_addr_reg[9],
                                          sn_addr_reg[10], sn_addr_reg[11]};
                            f_nw = 3'd2;
                        end
                    end
                    else if (ver == gtpu_pkg::IP_VER6 && ip_len >= 17'd40)
                    begin
                        f_status = gtpu_pkg::STATUS_V6;
                        f_proto  = sn_b6_reg;
                        if ((sn_b6_reg == gtpu_pkg::PROTO_TCP
                             || sn_b6_reg == gtpu_pkg::PROTO_UDP)
                            && off_ext + 18'd44 <= {1'b0, ft})
                        begin
                            f_status = gtpu_pkg::STATUS_V6_PORTS;
                            f_ports  = {sn_v6p_reg[0], sn_v6p_reg[1],
                                        sn_v6p_reg[2], sn_v6p_reg[3]};
                        end
                        f_poff = sn_ins_reg + 17'd40;
                        f_plen = 16'(ip_len - 17'd40);
                        for (int w = 0; w < 4; w++)
                            f_words[w] = {sn_addr_reg[w*8],   sn_addr_reg[w*8+1],
                                          sn_addr_reg[w*8+2], sn_addr_reg[w*8+3],
                                          sn_addr_reg[w*8+4], sn_addr_reg[w*8+5],
                                          sn_addr_reg[w*8+6], sn_addr_reg[w*8+7]};
                        f_nw = 3'd4;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_nw_reg    <= '0;
        end
        else if (snap_adv)
        begin
            res_valid_reg <= 1'b1;
            res_idx_reg   <= '0;
            res_nw_reg    <= f_nw;
        end
        else if (out_fire)
        begin
            if (out_last)
                res_valid_reg <= 1'b0;
            else
                res_idx_reg <= res_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            res_status_reg <= f_status;
            res_msg_reg    <= f_accept ? sn_msg_reg : 8'd0;
            res_tid_reg    <= f_accept ? sn_tid_reg : 32'd0;
            res_seq_reg    <= (f_accept && f_hdr) ? sn_seq_reg : 16'd0;
            res_cnt_reg    <= f_accept ? sn_cnt_reg : 8'd0;
            res_ok_reg     <= f_accept && !sn_fail_reg;
            res_proto_reg  <= f_proto;
            res_ports_reg  <= f_ports;
            res_poff_reg   <= f_poff;
            res_plen_reg   <= f_plen;
            res_words_reg  <= f_words;
        end
    end

    logic [1:0] wsel;
    assign wsel = 2'(res_idx_reg - 3'd1);

    assign results.valid            = res_valid_reg;
    assign results.last_result      = out_last;
    assign results.addr_word        = (res_idx_reg == 3'd0) ? 64'd0 : res_words_reg[wsel];
    assign results.status           = res_status_reg;
    assign results.msg_kind         = res_msg_reg;
    assign results.tunnel_id        = res_tid_reg;
    assign results.seq_no           = res_seq_reg;
    assign results.ext_header_count = res_cnt_reg;
    assign results.ext_chain_ok     = res_ok_reg;
    assign results.inner_protocol   = res_proto_reg;
    assign results.port_pair        = res_ports_reg;
    assign results.pay_offset       = res_poff_reg;
    assign results.pay_length       = res_plen_reg;

    `GTPU_ASSERT_NEXT(a_last_loads_snap, clk, rst_n, in_fire && pkt_bytes.last_byte, snap_valid_reg)
    `GTPU_ASSERT_NEXT(a_last_clears_pos, clk, rst_n, in_fire && pkt_bytes.last_byte, pos_reg == 17'd0)
    `GTPU_ASSERT_IMPLY(a_idx_in_range, clk, rst_n, res_valid_reg, res_idx_reg <= res_nw_reg)
    `GTPU_ASSERT_NEXT(a_drain_empties, clk, rst_n, out_fire && out_last && !snap_valid_reg, !res_valid_reg)

endmodule
